// File: sv/anemometer_pulse_speed_averager_core_defines.svh
// ----------------------------------------------------------------------------
// anemometer pulse speed averager: assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ANEMOMETER_PULSE_SPEED_AVERAGER_CORE_DEFINES_SVH
`define ANEMOMETER_PULSE_SPEED_AVERAGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define APSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsa assertion failed");
// next-cycle implication
`define APSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsa assertion failed");
`else
`define APSA_ASSERT_IMP(lbl, ante, cons)
`define APSA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/apsa_pkg.sv
// ----------------------------------------------------------------------------
// apsa_pkg
// shared constants, codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
`default_nettype none

package apsa_pkg;

    // ring of recent speeds
    localparam int RING_DEPTH = 10;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int SPEED_W    = 16;
    localparam int SUM_W      = $clog2(RING_DEPTH * 65535 + 1);

    // serial divider
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // km/h display: floor(x / 10) as (x * RECIP) >> RECIP_SHIFT for x < 2^X36_W
    localparam int X36_W       = SPEED_W + 6;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 23'd6710887;
    localparam int SHOWN_W     = 18;

    // ports
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_NUM  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RPM_FACTOR = 2'd2;

    // register reset values
    localparam logic [31:0] SPEED_NUM_RST  = 32'd235620000;
    localparam logic [31:0] TIMEOUT_RST    = 32'd3000000;
    localparam logic [15:0] RPM_FACTOR_RST = 16'd41721;

    // command codes
    localparam logic [IN_TUSER_W-1:0] CMD_PULSE  = 2'd0;
    localparam logic [IN_TUSER_W-1:0] CMD_UNIT   = 2'd1;
    localparam logic [IN_TUSER_W-1:0] CMD_SAMPLE = 2'd2;

    typedef struct packed {
        logic take_item;
        logic check;
        logic push_zero;
        logic start_spd;
        logic push_spd;
        logic start_mean;
        logic mean_zero;
        logic latch_mean;
        logic post1;
        logic post2;
        logic load_out;
    } apsa_cmd_t;

    typedef struct packed {
        logic in_sample;
        logic stall;
        logic have_interval;
        logic fill_nz;
        logic div_busy;
        logic div_done;
        logic out_free;
    } apsa_sts_t;

endpackage

`default_nettype wire

// File: sv/apsa_div.sv
// ----------------------------------------------------------------------------
// apsa_div
// restoring divider, one quotient bit per cycle, dividend left-aligned
// ----------------------------------------------------------------------------
`default_nettype none

module apsa_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [apsa_pkg::DIV_W-1:0]     dividend,
    input  wire logic [apsa_pkg::DIV_W-1:0]     divisor,
    input  wire logic [apsa_pkg::DIV_CNT_W-1:0] steps,
    output logic                               busy,
    output logic                               done,
    output logic [apsa_pkg::DIV_W-1:0]          quotient
);
    import apsa_pkg::*;

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        shifted  = {rem_reg, q_reg[DIV_W-1]};
        diff     = shifted - {1'b0, d_reg};
        ge       = !diff[DIV_W];
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        q_next   = {q_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= steps;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = run_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: sv/apsa_dp.sv
// ----------------------------------------------------------------------------
// apsa_dp
// datapath: registers, pulse timing, speed ring, divider, output stage
// ----------------------------------------------------------------------------
`default_nettype none
`include "anemometer_pulse_speed_averager_core_defines.svh"

module apsa_dp
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire apsa_pkg::apsa_cmd_t               cmd,
    output apsa_pkg::apsa_sts_t                    sts,
    input  wire logic                             cfg_we,
    input  wire logic [apsa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [apsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [apsa_pkg::IN_TUSER_W-1:0]   in_command,
    input  wire logic [apsa_pkg::IN_TDATA_W-1:0]   in_now,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [apsa_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic [apsa_pkg::OUT_TUSER_W-1:0]       m_tuser
);
    import apsa_pkg::*;

    // configuration
    logic [31:0] speed_num_reg;
    logic [31:0] timeout_reg;
    logic [15:0] rpm_factor_reg;

    // pulse timing and unit
    logic [31:0] last_pulse_reg;
    logic [31:0] interval_reg;
    logic        kmh_reg;
    logic [31:0] now_reg;

    // ring
    logic [SPEED_W-1:0] ring_reg [RING_DEPTH];
    logic [PTR_W-1:0]   wp_reg;
    logic               full_reg;
    logic [SUM_W-1:0]   sum_reg;

    // sample results
    logic               stall_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [SPEED_W-1:0] mean_reg;
    logic [15:0]        rpm_reg;
    logic [X36_W-1:0]   x36_reg;
    logic [SHOWN_W-1:0] shown_reg;

    // output stage
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_unit_reg;

    logic [31:0]              age;
    logic                     stall;
    logic [FILL_W-1:0]        fill;
    logic                     push;
    logic [SPEED_W-1:0]       push_val;
    logic [SPEED_W-1:0]       spd_sat;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_divisor;
    logic [DIV_CNT_W-1:0]     div_steps;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic [31:0]              rpm_prod;
    logic [X36_W+RECIP_W-1:0] shown_prod;

    assign age   = now_reg - last_pulse_reg;
    assign stall = age > timeout_reg;
    assign fill  = full_reg ? FILL_W'(RING_DEPTH) : FILL_W'(wp_reg);

    assign spd_sat  = (|div_q[DIV_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : div_q[SPEED_W-1:0];
    assign push     = cmd.push_zero | cmd.push_spd;
    assign push_val = cmd.push_zero ? '0 : spd_sat;

    // divider operand select: speed divide or mean divide
    always_comb
    begin
        div_start = cmd.start_spd | cmd.start_mean;
        if (cmd.start_mean)
        begin
            div_dividend = DIV_W'(sum_reg) << (DIV_W - SUM_W);
            div_divisor  = DIV_W'(fill);
            div_steps    = DIV_CNT_W'(SUM_W);
        end
        else
        begin
            div_dividend = speed_num_reg;
            div_divisor  = interval_reg;
            div_steps    = DIV_CNT_W'(DIV_W);
        end
    end

    apsa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rpm_prod   = 32'(mean_reg) * 32'(rpm_factor_reg);
    assign shown_prod = (X36_W+RECIP_W)'(x36_reg) * (X36_W+RECIP_W)'(RECIP_TEN);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_num_reg  <= SPEED_NUM_RST;
            timeout_reg    <= TIMEOUT_RST;
            rpm_factor_reg <= RPM_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SPEED_NUM:  speed_num_reg  <= cfg_wdata;
                REG_TIMEOUT:    timeout_reg    <= cfg_wdata;
                REG_RPM_FACTOR: rpm_factor_reg <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    // pulse timing, unit toggle, ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg <= '0;
            interval_reg   <= '0;
            kmh_reg        <= 1'b0;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            sum_reg        <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.take_item && in_command == CMD_PULSE)
            begin
                interval_reg   <= in_now - last_pulse_reg;
                last_pulse_reg <= in_now;
            end
            if (cmd.take_item && in_command == CMD_UNIT)
            begin
                kmh_reg <= !kmh_reg;
            end
            if (push)
            begin
                ring_reg[wp_reg] <= push_val;
                sum_reg          <= sum_reg - SUM_W'(ring_reg[wp_reg]) + SUM_W'(push_val);
                if (wp_reg == PTR_W'(RING_DEPTH - 1))
                begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
        end
    end

    // sample working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            now_reg <= in_now;
        end
        if (cmd.check)
        begin
            stall_reg <= stall;
        end
        if (cmd.start_mean || cmd.mean_zero)
        begin
            fill_reg <= fill;
        end
        if (cmd.mean_zero)
        begin
            mean_reg <= '0;
        end
        else if (cmd.latch_mean)
        begin
            mean_reg <= div_q[SPEED_W-1:0];
        end
        if (cmd.post1)
        begin
            rpm_reg <= rpm_prod[31:16];
            x36_reg <= (X36_W'(mean_reg) << 5) + (X36_W'(mean_reg) << 2);
        end
        if (cmd.post2)
        begin
            shown_reg <= kmh_reg ? shown_prod[RECIP_SHIFT +: SHOWN_W] : SHOWN_W'(mean_reg);
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {1'b0, 4'(fill_reg), stall_reg, shown_reg, rpm_reg, mean_reg};
            out_unit_reg <= kmh_reg;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.in_sample     = (in_command == CMD_SAMPLE);
        sts.stall         = stall;
        sts.have_interval = |interval_reg;
        sts.fill_nz       = |fill;
        sts.div_busy      = div_busy;
        sts.div_done      = div_done;
        sts.out_free      = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_unit_reg;

    `APSA_ASSERT_NXT(a_push_fills, push, sts.fill_nz)
    `APSA_ASSERT_NXT(a_load_valid, cmd.load_out, out_valid_reg)
    `APSA_ASSERT_NXT(a_zero_no_grow, cmd.push_zero, sum_reg <= $past(sum_reg))

endmodule

`default_nettype wire

// File: sv/apsa_ctrl.sv
// ----------------------------------------------------------------------------
// apsa_ctrl
// controller: input handshake and sample sequencing
// ----------------------------------------------------------------------------
`default_nettype none
`include "anemometer_pulse_speed_averager_core_defines.svh"

module apsa_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire apsa_pkg::apsa_sts_t  sts,
    output apsa_pkg::apsa_cmd_t       cmd
);
    import apsa_pkg::*;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_CHECK      = 3'd1;
    localparam logic [2:0] ST_DIV_SPD    = 3'd2;
    localparam logic [2:0] ST_MEAN_START = 3'd3;
    localparam logic [2:0] ST_DIV_MEAN   = 3'd4;
    localparam logic [2:0] ST_POST1      = 3'd5;
    localparam logic [2:0] ST_POST2      = 3'd6;
    localparam logic [2:0] ST_OUT        = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item = accept;
                if (accept && sts.in_sample)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.stall)
                begin
                    cmd.push_zero = 1'b1;
                    state_next    = ST_MEAN_START;
                end
                else if (sts.have_interval)
                begin
                    cmd.start_spd = 1'b1;
                    state_next    = ST_DIV_SPD;
                end
                else
                begin
                    state_next = ST_MEAN_START;
                end
            end
            ST_DIV_SPD:
            begin
                if (sts.div_done)
                begin
                    cmd.push_spd = 1'b1;
                    state_next   = ST_MEAN_START;
                end
            end
            ST_MEAN_START:
            begin
                if (sts.fill_nz)
                begin
                    cmd.start_mean = 1'b1;
                    state_next     = ST_DIV_MEAN;
                end
                else
                begin
                    cmd.mean_zero = 1'b1;
                    state_next    = ST_POST1;
                end
            end
            ST_DIV_MEAN:
            begin
                if (sts.div_done)
                begin
                    cmd.latch_mean = 1'b1;
                    state_next     = ST_POST1;
                end
            end
            ST_POST1:
            begin
                cmd.post1  = 1'b1;
                state_next = ST_POST2;
            end
            ST_POST2:
            begin
                cmd.post2  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `APSA_ASSERT_NXT(a_sample_starts, accept && sts.in_sample, state_reg == ST_CHECK)
    `APSA_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free)
    `APSA_ASSERT_IMP(a_div_start_idle, cmd.start_spd || cmd.start_mean, !sts.div_busy)

endmodule

`default_nettype wire

// File: sv/anemometer_pulse_speed_averager_core.sv
// pulse and unit beats update state at the accepting edge, no result, and pass every
//   cycle between samples; a waiting result holds only the next sample, at its output step
// sample beat: check, speed divide if not stalled and an interval is known, ring push,
//   mean divide unless the ring is empty, post1, post2, output register; the 32-step and
//   20-step divides share one divider, and no beat is taken until the result is loaded
// reset: rst_n async active low clears timing, unit, ring and sum, restores registers
// ----------------------------------------------------------------------------
// anemometer_pulse_speed_averager_core
// pulse-period tachometer with a moving average over recent speed samples
// ----------------------------------------------------------------------------
`default_nettype none

module anemometer_pulse_speed_averager_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [apsa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [apsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input beats
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [apsa_pkg::IN_TDATA_W-1:0]   s_tdata,   // now_us
    input  wire logic [apsa_pkg::IN_TUSER_W-1:0]   s_tuser,   // command
    // result beats
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // avg_speed_mms, rpm_tenths, shown_speed, stalled, fill_count, zero pad
    output logic [apsa_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic [apsa_pkg::OUT_TUSER_W-1:0]       m_tuser    // unit_kmh
);
    import apsa_pkg::*;

    apsa_cmd_t cmd;
    apsa_sts_t sts;

    // controller walks a sample through check, speed divide, ring push,
    // mean divide, rpm and unit scaling, then hands it to the output register
    apsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath holds all state but the controller's sequence, including the shared divider and the output stage
    apsa_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_command (s_tuser),
        .in_now     (s_tdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: bench/anemometer_pulse_speed_averager_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anemometer_pulse_speed_averager_core_tb
// drives pulse, unit and sample beats and checks every sample report against a
// behavioral copy of the averager kept in the bench or a fixed directed report,
// over several register settings and idle patterns on both sides of the stream
// ----------------------------------------------------------------------------

module anemometer_pulse_speed_averager_core_tb;

    import apsa_pkg::*;

    // command code that the block must ignore
    localparam logic [IN_TUSER_W-1:0] CMD_SPARE = 2'd3;

    localparam int SETTLE_CYCLES = 120;   // covers the longest sample latency
    localparam int HOLD_CYCLES   = 400;   // long receiver stall
    localparam int PHASES        = 6;
    localparam int BEATS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS = 20;

    // one sample report, field by field
    typedef struct packed {
        logic [15:0] avg_mms;
        logic [15:0] rpm_tenths;
        logic [17:0] shown;
        logic        kmh;
        logic        stalled;
        logic [3:0]  fill;
    } speed_report_t;

    // directed stimulus row; want is used only when fixed is set
    typedef struct packed {
        logic [IN_TUSER_W-1:0] cmd;
        logic [31:0]           now;
        bit                    fixed;
        speed_report_t         want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;     // now_us
    logic [IN_TUSER_W-1:0] s_tuser;     // command
    logic m_tvalid;
    logic m_tready;
    // avg_speed_mms, rpm_tenths, shown_speed, stalled, fill_count, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;    // unit_kmh

    anemometer_pulse_speed_averager_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench copy of the averager: registers and state
    // ------------------------------------------------------------------
    logic [31:0] speed_num;
    logic [31:0] stall_limit;
    logic [15:0] rpm_q16;

    logic [31:0] pulse_stamp;
    logic [31:0] pulse_gap;
    logic        kmh_mode;
    logic [15:0] speed_hist [RING_DEPTH];
    int          hist_pos;
    logic        hist_full;
    logic [31:0] hist_sum;

    speed_report_t pending_reports [$];

    int error_count     = 0;
    int beats_sent      = 0;
    int reports_checked = 0;
    int stall_samples   = 0;
    int capped_speeds   = 0;

    // idle percentages for each side, and the long-stall request
    int  send_gap_pct  = 0;
    int  recv_hold_pct = 0;
    bit  hold_req      = 1'b0;

    function automatic void push_speed(input logic [15:0] v);
        hist_sum = hist_sum - speed_hist[hist_pos] + v;
        speed_hist[hist_pos] = v;
        hist_pos++;
        if (hist_pos >= RING_DEPTH)
        begin
            hist_pos  = 0;
            hist_full = 1'b1;
        end
    endfunction

    // updates the bench state for one beat; returns 1 with the report for a sample
    function automatic bit compute_speed_report(input logic [IN_TUSER_W-1:0] cmd,
                                                 input logic [31:0] now,
                                                 output speed_report_t rep);
        logic [31:0] age;
        logic [31:0] quo;
        logic [31:0] fill;
        logic [31:0] mean;
        logic [47:0] prod;
        logic [31:0] shown;
        bit          stall;
        bit          made;
        rep   = '0;
        stall = 1'b0;
        made  = 1'b0;
        if (cmd == CMD_PULSE)
        begin
            pulse_gap   = now - pulse_stamp;
            pulse_stamp = now;
        end
        else if (cmd == CMD_UNIT)
        begin
            kmh_mode = !kmh_mode;
        end
        else if (cmd == CMD_SAMPLE)
        begin
            age = now - pulse_stamp;
            // strictly older than the limit: push a zero speed
            if (age > stall_limit)
            begin
                push_speed(16'd0);
                stall = 1'b1;
            end
            else if (pulse_gap != 32'd0)
            begin
                quo = speed_num / pulse_gap;
                if (quo > 32'hFFFF)
                    capped_speeds++;
                push_speed((quo > 32'hFFFF) ? 16'hFFFF : quo[15:0]);
            end
            // no interval yet and not stalled: nothing pushed, mean still reported
            fill = hist_full ? RING_DEPTH : hist_pos;
            mean = (fill != 0) ? hist_sum / fill : 32'd0;
            if (mean > 32'hFFFF)
                mean = 32'hFFFF;
            prod  = 48'(mean) * 48'(rpm_q16);
            shown = kmh_mode ? (mean * 32'd36) / 32'd10 : mean;
            rep.avg_mms    = mean[15:0];
            rep.rpm_tenths = prod[31:16];
            rep.shown      = shown[17:0];
            rep.kmh        = kmh_mode;
            rep.stalled    = stall;
            rep.fill       = fill[3:0];
            made = 1'b1;
        end
        // the spare command changes nothing
        return made;
    endfunction

    // ------------------------------------------------------------------
    // error reporting and result checking
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // every accepted result beat is held against the oldest pending report
    always @(posedge clk)
    begin
        speed_report_t got;
        speed_report_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got.avg_mms    = m_tdata[15:0];
            got.rpm_tenths = m_tdata[31:16];
            got.shown      = m_tdata[49:32];
            got.stalled    = m_tdata[50];
            got.fill       = m_tdata[54:51];
            got.kmh        = m_tuser[0];
            if (pending_reports.size() == 0)
            begin
                flag_error("result beat with no sample pending");
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("avg_speed_mms", want.avg_mms, got.avg_mms);
                check_field("rpm_tenths", want.rpm_tenths, got.rpm_tenths);
                check_field("shown_speed", want.shown, got.shown);
                check_field("unit_kmh", want.kmh, got.kmh);
                check_field("stalled", want.stalled, got.stalled);
                check_field("fill_count", want.fill, got.fill);
            end
        end
    end

    // receiver side: random ready, plus one long hold-off when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                // output register fills, block stops taking beats
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_hold_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // called right after a falling edge; returns right after the falling edge
    // that follows acceptance, with the beat still driven
    task automatic send_beat(input logic [IN_TUSER_W-1:0] cmd, input logic [31:0] now);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= now;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // predict and queue after an accepted beat
    task automatic issue_beat(input logic [IN_TUSER_W-1:0] cmd, input logic [31:0] now,
                              input bit fixed, input speed_report_t want);
        speed_report_t rep;
        send_beat(cmd, now);
        if (compute_speed_report(cmd, now, rep))
        begin
            if (rep.stalled)
                stall_samples++;
            pending_reports.push_back(fixed ? want : rep);
        end
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] num, input logic [31:0] tmo,
                                input logic [31:0] rpm_word);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SPEED_NUM;
        cfg_wdata <= num;
        @(negedge clk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(negedge clk);
        cfg_addr  <= REG_RPM_FACTOR;
        cfg_wdata <= rpm_word;
        @(negedge clk);
        cfg_we    <= 1'b0;
        speed_num   = num;
        stall_limit = tmo;
        rpm_q16     = rpm_word[15:0];
    endtask

    // directed rows: extremes, wrap, timeout boundary, saturation, spare command
    stim_row_t directed [DIRECTED_ROWS] = '{
        // empty ring right after reset: all zero
        '{CMD_SAMPLE, 32'h0000_0000, 1'b1, '{16'd0, 16'd0, 18'd0, 1'b0, 1'b0, 4'd0}},
        // age wraps to the maximum: zero pushed, one entry
        '{CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, '{16'd0, 16'd0, 18'd0, 1'b0, 1'b1, 4'd1}},
        '{CMD_PULSE,  32'h0000_03E8, 1'b0, '0},
        '{CMD_PULSE,  32'h0000_03E9, 1'b0, '0},    // one microsecond interval
        '{CMD_SAMPLE, 32'h0000_03E9, 1'b0, '0},    // speed saturates
        '{CMD_UNIT,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_SAMPLE, 32'h0000_07D0, 1'b0, '0},    // km/h display
        '{CMD_SPARE,  32'h0000_3039, 1'b0, '0},    // ignored
        '{CMD_PULSE,  32'h8000_0000, 1'b0, '0},    // huge interval, speed 0
        '{CMD_SAMPLE, 32'h802D_C6C0, 1'b0, '0},    // age equals the limit
        '{CMD_SAMPLE, 32'h802D_C6C1, 1'b0, '0},    // one past the limit
        '{CMD_PULSE,  32'hFFFF_FFF0, 1'b0, '0},
        '{CMD_PULSE,  32'h0000_0010, 1'b0, '0},    // interval across the wrap
        '{CMD_SAMPLE, 32'h0000_0020, 1'b0, '0},
        '{CMD_UNIT,   32'h0000_0000, 1'b0, '0},
        '{CMD_PULSE,  32'h0005_0000, 1'b0, '0},
        '{CMD_SAMPLE, 32'h0005_0010, 1'b0, '0},
        '{CMD_SAMPLE, 32'h0005_0010, 1'b0, '0},
        '{CMD_UNIT,   32'h5555_AAAA, 1'b0, '0},
        '{CMD_SAMPLE, 32'h0005_A000, 1'b0, '0}
    };

    initial
    begin
        logic [31:0] t_now;
        logic [31:0] num;
        logic [31:0] tmo;
        logic [31:0] rpm_word;
        logic [IN_TUSER_W-1:0] cmd;
        int r;
        int pick;

        // every input known from time zero
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_SPEED_NUM;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PULSE;
        m_tready  = 1'b0;

        // bench state after reset
        speed_num   = SPEED_NUM_RST;
        stall_limit = TIMEOUT_RST;
        rpm_q16     = RPM_FACTOR_RST;
        pulse_stamp = '0;
        pulse_gap   = '0;
        kmh_mode    = 1'b0;
        foreach (speed_hist[i])
            speed_hist[i] = '0;
        hist_pos  = 0;
        hist_full = 1'b0;
        hist_sum  = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender rarely idles, receiver mostly stalls
        send_gap_pct  = 6;
        recv_hold_pct = 77;
        foreach (directed[i])
            issue_beat(directed[i].cmd, directed[i].now, directed[i].fixed,
                       directed[i].want);

        t_now = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: begin num = SPEED_NUM_RST; tmo = TIMEOUT_RST; rpm_word = RPM_FACTOR_RST; end
                1: begin num = 32'hFFFF_FFFF; tmo = 32'd0; rpm_word = 32'hFFFF_FFFF; end
                2: begin num = 32'd0; tmo = 32'hFFFF_FFFF; rpm_word = 32'hFFFF_0000; end
                3: begin num = $urandom; tmo = $urandom_range(1000, 5000000);
                         rpm_word = $urandom; end
                4: begin num = $urandom_range(1000000, 1000000000); tmo = 32'd2000000;
                         rpm_word = $urandom; end
                default: begin num = SPEED_NUM_RST; tmo = TIMEOUT_RST;
                               rpm_word = RPM_FACTOR_RST; end
            endcase
            program_regs(num, tmo, rpm_word);

            // idle pattern: sender light / receiver heavy, then swapped, then none
            if (p < 2)
            begin
                send_gap_pct  = 6;
                recv_hold_pct = 77;
            end
            else if (p < 4)
            begin
                send_gap_pct  = 77;
                recv_hold_pct = 6;
            end
            else
            begin
                send_gap_pct  = 0;
                recv_hold_pct = 0;
            end
            if (p == 0 || p == 4)
                hold_req = 1'b1;

            @(negedge clk);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // mostly a plausible pulse and sample stream with rare noise
                r = $urandom_range(0, 99);
                if (r < 40)
                    cmd = CMD_PULSE;
                else if (r < 48)
                    cmd = CMD_UNIT;
                else if (r < 97)
                    cmd = CMD_SAMPLE;
                else
                    cmd = CMD_SPARE;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    t_now = t_now + $urandom_range(1000, 200000);
                else if (pick < 75)
                    t_now = t_now + $urandom_range(0, 999);
                else if (pick < 92)
                    t_now = t_now + $urandom_range(200000, 4000000);
                else
                    t_now = $urandom;    // clock jump, anything goes
                issue_beat(cmd, t_now, 1'b0, '0);
            end
        end

        settle();
        if (pending_reports.size() != 0)
            flag_error("samples left without a result");

        $display("run: %0d beats over %0d register settings, %0d reports checked",
                 beats_sent, PHASES + 1, reports_checked);
        $display("run: %0d stalled samples, %0d saturated speeds, %0d errors",
                 stall_samples, capped_speeds, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/apsa_pkg.sv
sv/apsa_div.sv
sv/apsa_dp.sv
sv/apsa_ctrl.sv
sv/anemometer_pulse_speed_averager_core.sv
bench/anemometer_pulse_speed_averager_core_tb.sv
